FILE: src/packet_traffic_statistics_defines.svh
// Assertion macros used by the traffic statistics monitor.
`ifndef PACKET_TRAFFIC_STATISTICS_DEFINES_SVH
`define PACKET_TRAFFIC_STATISTICS_DEFINES_SVH

// Checked only while reset is released.
`define PTS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PTS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: src/pts_pkg.sv
`default_nettype none

package pts_pkg;

    localparam logic OP_PACKET  = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    localparam logic [7:0] MIN_CAPTURE_RESET = 8'd34;

    localparam int SIZE_BINS  = 6;
    localparam int GAP_BINS   = 8;
    localparam int BIN_ADDR_W = 3;
    localparam int STAT_IDX_W = 5;

    localparam logic [STAT_IDX_W-1:0] STAT_PACKETS   = 5'd0;
    localparam logic [STAT_IDX_W-1:0] STAT_BYTES     = 5'd1;
    localparam logic [STAT_IDX_W-1:0] STAT_FIRST     = 5'd2;
    localparam logic [STAT_IDX_W-1:0] STAT_LAST_TIME = 5'd3;
    localparam logic [STAT_IDX_W-1:0] STAT_MIN_SIZE  = 5'd4;
    localparam logic [STAT_IDX_W-1:0] STAT_MAX_SIZE  = 5'd5;
    localparam logic [STAT_IDX_W-1:0] STAT_GAP_SUM   = 5'd6;
    localparam logic [STAT_IDX_W-1:0] STAT_GAP_COUNT = 5'd7;
    localparam logic [STAT_IDX_W-1:0] STAT_GAP_MIN   = 5'd8;
    localparam logic [STAT_IDX_W-1:0] STAT_GAP_MAX   = 5'd9;
    localparam logic [STAT_IDX_W-1:0] STAT_SIZE_BIN0 = 5'd10;
    localparam logic [STAT_IDX_W-1:0] STAT_GAP_BIN0  = 5'd16;
    localparam logic [STAT_IDX_W-1:0] STAT_FINAL     = 5'd23;

    localparam logic signed [63:0] GAP_SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] GAP_SUM_MIN = 64'sh8000_0000_0000_0000;

    localparam logic [15:0] SIZE_EDGE [SIZE_BINS-1] = '{
        16'd100, 16'd300, 16'd600, 16'd900, 16'd1200
    };

    localparam logic signed [63:0] GAP_EDGE [GAP_BINS-1] = '{
        64'sd100, 64'sd500, 64'sd1000, 64'sd2000, 64'sd5000, 64'sd10000, 64'sd20000
    };

    typedef struct packed {
        logic                  inc_valid;
        logic [BIN_ADDR_W-1:0] inc_addr;
        logic                  ro_sel;
        logic [BIN_ADDR_W-1:0] ro_addr;
    } t_bin_cmd;

    function automatic logic [BIN_ADDR_W-1:0] size_bin(input logic [15:0] len);
        logic [BIN_ADDR_W-1:0] bin;
        bin = '0;
        for (int k = 0; k < SIZE_BINS - 1; k++) begin
            if (len >= SIZE_EDGE[k]) begin
                bin = BIN_ADDR_W'(k + 1);
            end
        end
        return bin;
    endfunction

    function automatic logic [BIN_ADDR_W-1:0] gap_bin(input logic signed [63:0] gap);
        logic [BIN_ADDR_W-1:0] bin;
        bin = '0;
        for (int k = 0; k < GAP_BINS - 1; k++) begin
            if (gap >= GAP_EDGE[k]) begin
                bin = BIN_ADDR_W'(k + 1);
            end
        end
        return bin;
    endfunction

endpackage

`default_nettype wire

FILE: src/pts_if.sv
`default_nettype none

interface pts_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [62:0] timestamp_us;
    logic [15:0] wire_length;
    logic [15:0] captured_length;

    modport source (
        output valid, operation, timestamp_us, wire_length, captured_length,
        input  ready
    );
    modport sink (
        input  valid, operation, timestamp_us, wire_length, captured_length,
        output ready
    );
endinterface

interface pts_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         stat_index;
    logic signed [63:0] stat_value;
    logic               last_item;

    modport source (
        output valid, stat_index, stat_value, last_item,
        input  ready
    );
    modport sink (
        input  valid, stat_index, stat_value, last_item,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/pts_bin_mem.sv
`default_nettype none

module pts_bin_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_written;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_we) begin
                r_written[i_waddr] <= 1'b1;
            end
            r_rd_written <= r_written[i_raddr];
        end
    end

    assign o_rdata = r_rd_written ? r_rdata : '0;

endmodule

`default_nettype wire

FILE: src/pts_bin_bank.sv
`default_nettype none

module pts_bin_bank #(
    parameter int DEPTH       = 8,
    parameter int COUNT_WIDTH = 48
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire pts_pkg::t_bin_cmd      i_cmd,
    output logic      [COUNT_WIDTH-1:0] o_ro_count
);

    localparam int                     AW        = $clog2(DEPTH);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [AW-1:0]          rd_addr;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] n_count;

    logic                   r_s2_valid;
    logic [AW-1:0]          r_s2_addr;
    logic                   r_fwd;
    logic [COUNT_WIDTH-1:0] r_fwd_val;

    assign rd_addr = i_cmd.ro_sel ? i_cmd.ro_addr[AW-1:0] : i_cmd.inc_addr[AW-1:0];

    pts_bin_mem #(
        .DEPTH (DEPTH),
        .WIDTH (COUNT_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_s2_valid),
        .i_waddr (r_s2_addr),
        .i_wdata (n_count),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // A back-to-back increment of the same bin reads stale data, so the
    // value being written is forwarded instead.
    assign cur_count = r_fwd ? r_fwd_val : rd_data;
    assign n_count   = (cur_count == COUNT_MAX) ? cur_count
                                                : cur_count + COUNT_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s2_valid <= i_cmd.inc_valid;
            r_fwd      <= r_s2_valid && i_cmd.inc_valid
                          && (r_s2_addr == i_cmd.inc_addr[AW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_addr <= i_cmd.inc_addr[AW-1:0];
        r_fwd_val <= n_count;
    end

    assign o_ro_count = rd_data;

endmodule

`default_nettype wire

FILE: src/packet_traffic_statistics.sv
// Packet traffic statistics monitor.
// Input channel i_pkt carries one transaction per packet record or read-out
// request; each o_stat transaction carries one statistic of a read-out.
// The capture length threshold is written through i_cfg_we/i_cfg_wdata.
// A packet record, accepted every cycle outside a read-out, gives no output
// and passes a three-stage pipeline: gap calculation, scalar update with
// histogram bin read, and histogram write-back. The bins live in two small
// memories with registered reads, updated read-modify-write with forwarding.
// A read-out request holds i_pkt.ready low while the 24 statistics are
// fetched one per cycle while o_stat is not stalled; each passes the fetch
// register, then the output register, and the last has last_item set.
// When o_stat stalls, the fetch holds and the input stays blocked until the
// last statistic has reached the output register.
// Synchronous reset clears every statistic and loads the capture threshold
// with 34; histogram entries read as zero until first incremented.
`default_nettype none

`include "packet_traffic_statistics_defines.svh"

module packet_traffic_statistics #(
    parameter int COUNT_WIDTH = 48
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    pts_in_if.sink          i_pkt,
    pts_out_if.source       o_stat
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int                     IW        = pts_pkg::STAT_IDX_W;
    localparam int                     BW        = pts_pkg::BIN_ADDR_W;

    logic [7:0] r_min_cap;

    logic in_acc;
    logic pkt_take;
    logic ro_start;

    // Stage one.
    logic                      r_p_valid;
    logic [62:0]               r_p_ts;
    logic [15:0]               r_p_wire;
    logic signed [63:0]        r_p_gap;
    logic                      r_p_has_gap;
    logic [62:0]               r_prev;

    // Statistics.
    logic                      r_seen;
    logic [62:0]               r_first_time;
    logic [62:0]               r_last_time;
    logic [COUNT_WIDTH-1:0]    r_pkt_cnt;
    logic [COUNT_WIDTH-1:0]    r_byte_cnt;
    logic [15:0]               r_min_size;
    logic [15:0]               r_max_size;
    logic signed [63:0]        r_gap_total;
    logic [COUNT_WIDTH-1:0]    r_gap_tally;
    logic signed [63:0]        r_min_gap;
    logic signed [63:0]        r_max_gap;

    logic [COUNT_WIDTH:0]      byte_sum;
    logic [COUNT_WIDTH-1:0]    n_byte_cnt;
    logic [COUNT_WIDTH-1:0]    n_pkt_cnt;
    logic [COUNT_WIDTH-1:0]    n_gap_tally;
    logic signed [63:0]        gap_sum;
    logic                      gap_ovf;
    logic signed [63:0]        n_gap_total;
    logic [15:0]               n_min_size;

    pts_pkg::t_bin_cmd         size_cmd;
    pts_pkg::t_bin_cmd         gap_cmd;
    logic [COUNT_WIDTH-1:0]    size_count;
    logic [COUNT_WIDTH-1:0]    gap_count;

    // Read-out fetch and output register.
    logic                      r_f_valid;
    logic [IW-1:0]             r_f_idx;
    logic                      out_free;
    logic                      ro_load;
    logic [IW-1:0]             ro_target;
    logic signed [63:0]        stat_val;

    logic                      r_o_valid;
    logic [IW-1:0]             r_o_idx;
    logic signed [63:0]        r_o_value;
    logic                      r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cap <= pts_pkg::MIN_CAPTURE_RESET;
        end else if (i_cfg_we) begin
            r_min_cap <= i_cfg_wdata;
        end
    end

    assign i_pkt.ready = !r_f_valid;
    assign in_acc      = i_pkt.valid && i_pkt.ready;
    assign pkt_take    = in_acc && (i_pkt.operation == pts_pkg::OP_PACKET)
                         && (i_pkt.captured_length >= 16'(r_min_cap));
    assign ro_start    = in_acc && (i_pkt.operation == pts_pkg::OP_READOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_prev    <= '0;
        end else begin
            r_p_valid <= pkt_take;
            if (pkt_take) begin
                r_prev <= i_pkt.timestamp_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pkt_take) begin
            r_p_ts      <= i_pkt.timestamp_us;
            r_p_wire    <= i_pkt.wire_length;
            r_p_gap     <= $signed({1'b0, i_pkt.timestamp_us}) - $signed({1'b0, r_prev});
            r_p_has_gap <= (r_prev != '0);
        end
    end

    assign byte_sum    = {1'b0, r_byte_cnt} + (COUNT_WIDTH + 1)'(r_p_wire);
    assign n_byte_cnt  = byte_sum[COUNT_WIDTH] ? COUNT_MAX : byte_sum[COUNT_WIDTH-1:0];
    assign n_pkt_cnt   = (r_pkt_cnt == COUNT_MAX) ? r_pkt_cnt : r_pkt_cnt + COUNT_WIDTH'(1);
    assign n_gap_tally = (r_gap_tally == COUNT_MAX) ? r_gap_tally
                                                    : r_gap_tally + COUNT_WIDTH'(1);
    assign gap_sum     = r_gap_total + r_p_gap;
    assign gap_ovf     = (r_gap_total[63] == r_p_gap[63]) && (gap_sum[63] != r_gap_total[63]);
    assign n_gap_total = gap_ovf ? (r_p_gap[63] ? pts_pkg::GAP_SUM_MIN : pts_pkg::GAP_SUM_MAX)
                                 : gap_sum;
    assign n_min_size  = (!r_seen || (r_p_wire < r_min_size)) ? r_p_wire : r_min_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_first_time <= '0;
            r_last_time  <= '0;
            r_pkt_cnt    <= '0;
            r_byte_cnt   <= '0;
            r_min_size   <= '0;
            r_max_size   <= '0;
            r_gap_total  <= '0;
            r_gap_tally  <= '0;
            r_min_gap    <= '0;
            r_max_gap    <= '0;
        end else if (r_p_valid) begin
            r_seen      <= 1'b1;
            r_last_time <= r_p_ts;
            r_pkt_cnt   <= n_pkt_cnt;
            r_byte_cnt  <= n_byte_cnt;
            r_min_size  <= n_min_size;
            if (r_p_wire > r_max_size) begin
                r_max_size <= r_p_wire;
            end
            if (!r_seen) begin
                r_first_time <= r_p_ts;
                r_min_gap    <= pts_pkg::GAP_SUM_MAX;
                r_max_gap    <= '0;
            end else if (r_p_has_gap) begin
                r_gap_total <= n_gap_total;
                r_gap_tally <= n_gap_tally;
                if (r_p_gap < r_min_gap) begin
                    r_min_gap <= r_p_gap;
                end
                if (r_p_gap > r_max_gap) begin
                    r_max_gap <= r_p_gap;
                end
            end
        end
    end

    assign out_free  = !r_o_valid || o_stat.ready;
    assign ro_load   = r_f_valid && out_free;
    assign ro_target = ro_load ? r_f_idx + IW'(1) : r_f_idx;

    always_comb begin
        size_cmd.inc_valid = r_p_valid;
        size_cmd.inc_addr  = pts_pkg::size_bin(r_p_wire);
        size_cmd.ro_sel    = r_f_valid;
        size_cmd.ro_addr   = '0;
        if ((ro_target >= pts_pkg::STAT_SIZE_BIN0) && (ro_target < pts_pkg::STAT_GAP_BIN0)) begin
            size_cmd.ro_addr = BW'(ro_target - pts_pkg::STAT_SIZE_BIN0);
        end

        gap_cmd.inc_valid = r_p_valid && r_p_has_gap;
        gap_cmd.inc_addr  = pts_pkg::gap_bin(r_p_gap);
        gap_cmd.ro_sel    = r_f_valid;
        gap_cmd.ro_addr   = '0;
        if (ro_target >= pts_pkg::STAT_GAP_BIN0) begin
            gap_cmd.ro_addr = BW'(ro_target - pts_pkg::STAT_GAP_BIN0);
        end
    end

    pts_bin_bank #(
        .DEPTH       (pts_pkg::SIZE_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_size_bins (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (size_cmd),
        .o_ro_count (size_count)
    );

    pts_bin_bank #(
        .DEPTH       (pts_pkg::GAP_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_gap_bins (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (gap_cmd),
        .o_ro_count (gap_count)
    );

    always_comb begin
        case (r_f_idx)
            pts_pkg::STAT_PACKETS:   stat_val = 64'(r_pkt_cnt);
            pts_pkg::STAT_BYTES:     stat_val = 64'(r_byte_cnt);
            pts_pkg::STAT_FIRST:     stat_val = 64'(r_first_time);
            pts_pkg::STAT_LAST_TIME: stat_val = 64'(r_last_time);
            pts_pkg::STAT_MIN_SIZE:  stat_val = 64'(r_min_size);
            pts_pkg::STAT_MAX_SIZE:  stat_val = 64'(r_max_size);
            pts_pkg::STAT_GAP_SUM:   stat_val = r_gap_total;
            pts_pkg::STAT_GAP_COUNT: stat_val = 64'(r_gap_tally);
            pts_pkg::STAT_GAP_MIN:   stat_val = r_min_gap;
            pts_pkg::STAT_GAP_MAX:   stat_val = r_max_gap;
            default: begin
                if (r_f_idx < pts_pkg::STAT_GAP_BIN0) begin
                    stat_val = 64'(size_count);
                end else begin
                    stat_val = 64'(gap_count);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_f_idx   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (ro_start) begin
                r_f_valid <= 1'b1;
                r_f_idx   <= pts_pkg::STAT_PACKETS;
            end else if (ro_load) begin
                if (r_f_idx == pts_pkg::STAT_FINAL) begin
                    r_f_valid <= 1'b0;
                end
                r_f_idx <= r_f_idx + IW'(1);
            end
            if (ro_load) begin
                r_o_valid <= 1'b1;
            end else if (o_stat.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ro_load) begin
            r_o_idx   <= r_f_idx;
            r_o_value <= stat_val;
            r_o_last  <= (r_f_idx == pts_pkg::STAT_FINAL);
        end
    end

    assign o_stat.valid      = r_o_valid;
    assign o_stat.stat_index = r_o_idx;
    assign o_stat.stat_value = r_o_value;
    assign o_stat.last_item  = r_o_last;

    `PTS_ASSERT(a_ro_starts_at_zero, ro_start |=> (r_f_valid && (r_f_idx == pts_pkg::STAT_PACKETS)), "read-out did not start at the first statistic")
    `PTS_ASSERT(a_ro_steps_by_one, (ro_load && (r_f_idx != pts_pkg::STAT_FINAL)) |=> (r_f_idx == $past(r_f_idx) + IW'(1)), "read-out index skipped a statistic")
    `PTS_ASSERT(a_ro_no_pkt_in_flight, r_f_valid |-> (!r_p_valid && !pkt_take), "packet update overlaps a read-out")
    `PTS_ASSERT(a_last_on_final, (o_stat.valid && o_stat.last_item) |-> (o_stat.stat_index == pts_pkg::STAT_FINAL), "last_item on a statistic other than the final one")
    `PTS_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_stat.valid, "output valid after reset")

endmodule

`default_nettype wire
